// ===== hdl/lfo_sine_and_envelope_top_defines.svh =====
// Assertion macros for the sine/envelope oscillator top level.
// No dependencies.
`ifndef LFO_SINE_AND_ENVELOPE_TOP_DEFINES_SVH
`define LFO_SINE_AND_ENVELOPE_TOP_DEFINES_SVH
// Assert that an implication holds on every clock edge outside reset.
`define LSE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Assert that an implication holds in the next cycle.
`define LSE_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== hdl/lse_pkg.sv =====
// Shared types, constants and sine table for the oscillator.
// No dependencies.
package lse_pkg;
  localparam int BLOCK_LEN = 128;
  localparam int SHAPE_POINTS = 11;
  localparam int BP_W = (BLOCK_LEN > 1) ? $clog2(BLOCK_LEN) : 1;
  localparam int SH_W = $clog2(SHAPE_POINTS);
  localparam int FRAC_BITS = 28;
  localparam logic [16:0] MAG_MAX = 17'd65534;
  localparam logic [15:0] LEVEL_MAX = 16'd32768;
  localparam logic [31:0] END_POS = 32'(SHAPE_POINTS - 1) << FRAC_BITS;
  // ceil(2^49 / 360): reciprocal for the degree-to-phase conversion
  localparam logic [49:0] ANGLE_RECIP = 50'd1563749870615;

  typedef enum logic [2:0] {
    FN_TICK = 3'd0, FN_SET_AMP = 3'd1, FN_GLIDE = 3'd2, FN_ANGLE = 3'd3,
    FN_RESTART = 3'd4, FN_SHAPE = 3'd5, FN_NOP6 = 3'd6, FN_NOP7 = 3'd7
  } func_t;

  typedef enum logic [2:0] {
    REG_MODE = 3'd0, REG_PHASE_STEP = 3'd1, REG_ENV_STEP = 3'd2,
    REG_ENV_PEAK = 3'd3, REG_ENV_FALL = 3'd4
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_MUL1, ST_MUL2
  } state_t;

  typedef struct packed {
    logic [2:0]         func;
    logic signed [15:0] value;
    logic [3:0]         point_index;
    logic [15:0]        point_level;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               envelope_done;
  } out_item_t;

  typedef struct packed {
    logic        mode_sine;
    logic [31:0] phase_step;
    logic [19:0] env_step;
    logic [14:0] env_peak;
    logic        env_falling;
  } cfg_t;

  function automatic logic signed [15:0] quarter_sine(input logic [6:0] k);
    logic signed [15:0] r;
    unique case (k)
      7'd0: r = 0;      7'd1: r = 804;    7'd2: r = 1608;   7'd3: r = 2410;
      7'd4: r = 3212;   7'd5: r = 4011;   7'd6: r = 4808;   7'd7: r = 5602;
      7'd8: r = 6393;   7'd9: r = 7179;   7'd10: r = 7962;  7'd11: r = 8739;
      7'd12: r = 9512;  7'd13: r = 10278; 7'd14: r = 11039; 7'd15: r = 11793;
      7'd16: r = 12539; 7'd17: r = 13279; 7'd18: r = 14010; 7'd19: r = 14732;
      7'd20: r = 15446; 7'd21: r = 16151; 7'd22: r = 16846; 7'd23: r = 17530;
      7'd24: r = 18204; 7'd25: r = 18868; 7'd26: r = 19519; 7'd27: r = 20159;
      7'd28: r = 20787; 7'd29: r = 21403; 7'd30: r = 22005; 7'd31: r = 22594;
      7'd32: r = 23170; 7'd33: r = 23731; 7'd34: r = 24279; 7'd35: r = 24811;
      7'd36: r = 25329; 7'd37: r = 25832; 7'd38: r = 26319; 7'd39: r = 26790;
      7'd40: r = 27245; 7'd41: r = 27683; 7'd42: r = 28105; 7'd43: r = 28510;
      7'd44: r = 28898; 7'd45: r = 29268; 7'd46: r = 29621; 7'd47: r = 29956;
      7'd48: r = 30273; 7'd49: r = 30571; 7'd50: r = 30852; 7'd51: r = 31113;
      7'd52: r = 31356; 7'd53: r = 31580; 7'd54: r = 31785; 7'd55: r = 31971;
      7'd56: r = 32137; 7'd57: r = 32285; 7'd58: r = 32412; 7'd59: r = 32521;
      7'd60: r = 32609; 7'd61: r = 32678; 7'd62: r = 32728; 7'd63: r = 32757;
      default: r = 32767;
    endcase
    return r;
  endfunction

  // Entry k of the 257-point table; k is 0..256.
  function automatic logic signed [15:0] sine_rom(input logic [8:0] k);
    logic signed [15:0] r;
    if (k <= 9'd64)       r = quarter_sine(7'(k));
    else if (k <= 9'd128) r = quarter_sine(7'(9'd128 - k));
    else if (k <= 9'd192) r = -quarter_sine(7'(k - 9'd128));
    else                  r = -quarter_sine(7'(9'd256 - k));
    return r;
  endfunction

  // trunc(m * 2^32 / 360) by reciprocal multiplication; exact for m in 0..359.
  function automatic logic [31:0] angle_step(input logic [8:0] m);
    logic [49:0] p;
    p = 50'(m) * ANGLE_RECIP;
    return p[48:17];
  endfunction
endpackage

// ===== hdl/lse_shape_ram.sv =====
// Envelope shape memory: one write port, one registered read port.
// Depends on lse_pkg.
module lse_shape_ram import lse_pkg::*; (
  input  logic            clk,
  input  logic            we,
  input  logic [SH_W-1:0] waddr,
  input  logic [15:0]     wdata,
  input  logic [SH_W-1:0] raddr,
  output logic [15:0]     rdata
);
  logic [15:0] mem [SHAPE_POINTS];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== hdl/lse_core.sv =====
// Sequencer: command decode, state update, shape reads and multipliers.
// Depends on lse_pkg and lse_shape_ram.
module lse_core import lse_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      res_valid,
  input  logic      res_stall,
  output out_item_t res_item,
  output logic      busy
);
  state_t state, state_next;
  logic [31:0] phase_acc;
  logic [8:0]  phase_angle;
  logic [16:0] magnitude, glide_count;
  logic        glide_up;
  logic [BP_W-1:0] block_pos;
  logic [31:0] env_pos;
  logic        env_ended;
  // Shape memory has no reset, so a never-written entry is read as zero by valid bits.
  logic [SHAPE_POINTS-1:0] shp_vld;

  logic        sh_we;
  logic [SH_W-1:0] sh_waddr, sh_raddr;
  logic [15:0] sh_wdata, sh_rdata;
  logic [SH_W-1:0] rd_idx;

  logic [15:0] ea, eb_m;
  logic signed [33:0] blend;
  logic signed [52:0] prod;
  logic        snap_sine, snap_end;
  logic [27:0] snap_frac;
  logic signed [15:0] out_sample;
  logic        out_done;
  logic        res_free;

  lse_shape_ram u_ram (
    .clk(clk), .we(sh_we), .waddr(sh_waddr), .wdata(sh_wdata),
    .raddr(sh_raddr), .rdata(sh_rdata)
  );

  logic take;
  assign take = in_valid && !in_stall;
  assign in_stall = (state != ST_IDLE);
  assign busy = (state != ST_IDLE);
  assign res_free = !res_valid || !res_stall;
  assign res_item.sample = out_sample;
  assign res_item.envelope_done = out_done;

  logic [16:0] amp2;
  logic [8:0]  ang;
  logic signed [17:0] gd;
  logic signed [9:0]  ad;
  logic [SH_W-1:0] seg;
  logic [3:0]  seg_full;

  always_comb begin
    amp2 = in_item.value[15] ? 17'd0 : {in_item.value[14:0], 1'b0};
    if (in_item.value[15]) ang = 9'd0;
    else if (in_item.value > 16'sd359) ang = 9'd359;
    else ang = in_item.value[8:0];
    gd = $signed({1'b0, amp2}) - $signed({1'b0, magnitude});
    ad = $signed({1'b0, ang}) - $signed({1'b0, phase_angle});
    seg_full = env_pos[31:28];
    if (env_ended) seg = SH_W'(SHAPE_POINTS - 1);
    else if (seg_full > 4'(SHAPE_POINTS - 2)) seg = SH_W'(SHAPE_POINTS - 2);
    else seg = SH_W'(seg_full);
  end

  assign sh_we = take && (in_item.func == FN_SHAPE) &&
                 (in_item.point_index < 4'(SHAPE_POINTS));
  assign sh_waddr = SH_W'(in_item.point_index);
  assign sh_wdata = (in_item.point_level > LEVEL_MAX) ? LEVEL_MAX : in_item.point_level;
  // First entry is read on the accept edge, the second one in READ.
  assign sh_raddr = (state == ST_IDLE) ? seg : SH_W'(rd_idx + SH_W'(1));

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (take && in_item.func == FN_TICK) state_next = ST_READ;
      ST_READ:  state_next = ST_MUL1;
      ST_MUL1:  state_next = ST_MUL2;
      ST_MUL2:  if (res_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // Output register: load from MUL2 when free, drop once taken.
  always_ff @(posedge clk) begin
    if (rst) res_valid <= 1'b0;
    else if (state == ST_MUL2 && res_free) res_valid <= 1'b1;
    else if (!res_stall) res_valid <= 1'b0;
  end

  logic signed [15:0] qv;
  logic [16:0] scale_c, scale_m;
  logic [8:0]  idx;
  logic [27:0] frac_e;
  logic [28:0] frac_c;
  logic [44:0] isum;
  logic [43:0] interp;
  logic [58:0] numv;

  assign idx = {1'b0, phase_acc[31:24]};
  assign scale_m = {1'b0, phase_acc[23:8]};
  assign scale_c = 17'h10000 - scale_m;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_acc <= '0; phase_angle <= '0; magnitude <= '0; glide_count <= '0;
      glide_up <= 1'b0; block_pos <= '0; env_pos <= '0; env_ended <= 1'b0;
      shp_vld <= '0; rd_idx <= '0;
    end else begin
      if (sh_we) shp_vld[sh_waddr] <= 1'b1;
      if (take) begin
        unique case (in_item.func)
          FN_TICK: begin
            snap_sine <= cfg.mode_sine;
            snap_end <= env_ended;
            snap_frac <= env_pos[27:0];
            rd_idx <= seg;
            if (cfg.mode_sine && block_pos == '0 && glide_count != '0) begin
              if (glide_up) begin
                if (magnitude < MAG_MAX) magnitude <= magnitude + 17'd1;
              end else if (magnitude != '0) magnitude <= magnitude - 17'd1;
              glide_count <= glide_count - 17'd1;
            end
            block_pos <= (block_pos == BP_W'(BLOCK_LEN - 1)) ? '0 : block_pos + BP_W'(1);
          end
          FN_SET_AMP: begin
            phase_acc <= '0;
            magnitude <= amp2;
          end
          FN_GLIDE: begin
            glide_up <= (gd > 0);
            glide_count <= (gd < 0) ? 17'(-gd) : 17'(gd);
          end
          FN_ANGLE: if (ad != 0) begin
            if (ad > 0) phase_acc <= phase_acc + angle_step(9'(ad));
            else phase_acc <= phase_acc - angle_step(9'(-ad));
            phase_angle <= ang;
          end
          FN_RESTART: begin
            env_pos <= '0;
            env_ended <= 1'b0;
          end
          FN_SHAPE, FN_NOP6, FN_NOP7: ;
          default: ;
        endcase
      end
      if (state == ST_READ) begin
        if (snap_sine) phase_acc <= phase_acc + cfg.phase_step;
        else if (!snap_end) begin
          if (env_pos + {12'd0, cfg.env_step} >= END_POS) env_ended <= 1'b1;
          env_pos <= env_pos + {12'd0, cfg.env_step};
        end
      end
    end
  end

  // READ: first shape entry, sine blend; MUL1: interpolated level, sine scaling;
  // MUL2: envelope scaling into the output register.
  always_ff @(posedge clk) begin
    unique case (state)
      ST_READ: begin
        ea <= shp_vld[rd_idx] ? sh_rdata : '0;
        blend <= 34'(sine_rom(idx)) * $signed({1'b0, scale_c}) +
                 34'(sine_rom(idx + 9'd1)) * $signed({1'b0, scale_m});
      end
      ST_MUL1: begin
        interp <= isum[43:0];
        prod <= 53'(blend) * $signed({1'b0, magnitude});
      end
      ST_MUL2: if (res_free) begin
        out_sample <= qv;
        out_done <= env_ended;
      end
      default: ;
    endcase
  end

  // Levels and peak are never negative, so the envelope product is too.
  always_comb begin
    frac_e = snap_end ? '0 : snap_frac;
    frac_c = 29'h1000_0000 - {1'b0, frac_e};
    eb_m = (!snap_end && shp_vld[SH_W'(rd_idx + SH_W'(1))]) ? sh_rdata : '0;
    isum = 45'(ea) * 45'(frac_c) + 45'(eb_m) * 45'(frac_e);
    numv = 59'(cfg.env_peak) * 59'(interp);
    if (snap_sine) qv = 16'(prod >>> 32);
    else if (cfg.env_falling) qv = -numv[58:43];
    else qv = numv[58:43];
  end
endmodule

// ===== hdl/lfo_sine_and_envelope_top.sv =====
// channel | dir | handshake          | payload
// in      | in  | in_valid/in_stall  | in_item_t
// out     | out | out_valid/out_stall| out_item_t
// cfg     | in  | cfg_we             | cfg_index, cfg_data
// A tick runs three steps (shape read and sine blend, interpolation and sine scaling,
// envelope scaling) in READ, MUL1 and MUL2; no new command is taken until IDLE again.
// Commands other than a tick finish in the accept cycle and give no transaction.
// A stalled result waits in the output register; the next tick holds in its last step.
// Reset is synchronous; the shape memory reads as zero until written.
// Depends on lse_pkg, lse_core, lse_shape_ram, lfo_sine_and_envelope_top_defines.svh.
`include "lfo_sine_and_envelope_top_defines.svh"
module lfo_sine_and_envelope_top import lse_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [31:0] cfg_data,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);
  cfg_t cfg;
  logic busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{mode_sine: 1'b1, phase_step: '0, env_step: '0, env_peak: '0,
               env_falling: 1'b0};
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE:       cfg.mode_sine <= cfg_data[0];
        REG_PHASE_STEP: cfg.phase_step <= cfg_data;
        REG_ENV_STEP:   cfg.env_step <= cfg_data[19:0];
        REG_ENV_PEAK:   cfg.env_peak <= cfg_data[14:0];
        REG_ENV_FALL:   cfg.env_falling <= cfg_data[0];
        default: ;
      endcase
    end
  end

  lse_core u_core (
    .clk(clk), .rst(rst), .cfg(cfg), .in_valid(in_valid), .in_stall(in_stall),
    .in_item(in_item), .res_valid(out_valid), .res_stall(out_stall),
    .res_item(out_item), .busy(busy)
  );

  `LSE_ASSERT_IMP(a_out_known, out_valid, !$isunknown(out_item), "result has unknown bits")
  `LSE_ASSERT_NXT(a_tick_busy, in_valid && !in_stall && in_item.func == FN_TICK, busy,
    "tick did not start work")
  `LSE_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_item),
    "stalled result changed")
  `LSE_ASSERT_NXT(a_cmd_no_res,
    in_valid && !in_stall && in_item.func != FN_TICK && !out_valid, !out_valid,
    "command produced a result")
endmodule
